FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same check with an explicit clock and reset.
`define ASSERT_CLK_RST(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error(msg);

`endif

FILE: design/bsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ROOT_WIDTH    = 25;
    localparam int TARGET_WIDTH  = DATA_WIDTH + FRACTION_BITS;
    localparam int SQ_WIDTH      = 2 * DATA_WIDTH;
    localparam int CMP_WIDTH     = (SQ_WIDTH > TARGET_WIDTH) ? SQ_WIDTH : TARGET_WIDTH;

    localparam logic [DATA_WIDTH-1:0] FIX_ONE = DATA_WIDTH'(1) << FRACTION_BITS;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ROOT_WIDTH-1:0] root_t;

    typedef struct packed {
        logic load;     // take a new radicand, set up the bounds
        logic square;   // register midpoint squared
        logic update;   // compare square with target, narrow the bounds
        logic capture;  // move the result into the output register
    } bsr_cmd_t;

    typedef struct packed {
        logic range_done;  // bounds are at most one LSB apart
        logic square_hit;  // registered square equals the target
    } bsr_status_t;

endpackage

`default_nettype wire

FILE: design/bsr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsr_in_if;
    import bsr_pkg::*;

    logic  valid;
    logic  ready;
    data_t radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

`default_nettype wire

FILE: design/bsr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsr_out_if;
    import bsr_pkg::*;

    logic  valid;
    logic  ready;
    root_t root;
    logic  exact_hit;

    modport source (output valid, output root, output exact_hit, input ready);
    modport sink   (input valid, input root, input exact_hit, output ready);
endinterface

`default_nettype wire

FILE: design/bsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bsr_pkg::data_t      radicand,
    input  wire bsr_pkg::bsr_cmd_t   cmd,
    output bsr_pkg::bsr_status_t     status,
    output bsr_pkg::root_t           root,
    output logic                     exact_hit
);
    import bsr_pkg::*;

    data_t                   lo_reg;
    data_t                   lo_next;
    data_t                   wid_reg;
    data_t                   wid_next;
    data_t                   mid_reg;
    data_t                   mid_next;
    logic [TARGET_WIDTH-1:0] target_reg;
    logic [SQ_WIDTH-1:0]     sq_reg;
    logic                    hit_reg;
    root_t                   root_reg;
    logic                    exact_reg;

    data_t                   hi_start;
    data_t                   half;
    data_t                   wid_below;
    logic [CMP_WIDTH-1:0]    sq_ext;
    logic [CMP_WIDTH-1:0]    target_ext;
    logic                    sq_equal;
    logic                    sq_below;

    always_comb
    begin
        hi_start   = (radicand < FIX_ONE) ? FIX_ONE : radicand;
        half       = wid_reg >> 1;
        wid_below  = wid_reg - half;
        sq_ext     = CMP_WIDTH'(sq_reg);
        target_ext = CMP_WIDTH'(target_reg);
        sq_equal   = (sq_ext == target_ext);
        sq_below   = (sq_ext < target_ext);

        // Both successor midpoints come from registered values; the compare only selects.
        if (sq_below)
        begin
            lo_next  = mid_reg;
            wid_next = wid_below;
            mid_next = mid_reg + (wid_below >> 1);
        end
        else
        begin
            lo_next  = lo_reg;
            wid_next = half;
            mid_next = lo_reg + (half >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg     <= '0;
            wid_reg    <= hi_start;
            mid_reg    <= hi_start >> 1;
            target_reg <= TARGET_WIDTH'(radicand) << FRACTION_BITS;
            hit_reg    <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (sq_equal)
            begin
                hit_reg <= 1'b1;
            end
            else
            begin
                lo_reg  <= lo_next;
                wid_reg <= wid_next;
                mid_reg <= mid_next;
            end
        end

        if (cmd.square)
        begin
            sq_reg <= SQ_WIDTH'(mid_reg) * SQ_WIDTH'(mid_reg);
        end

        if (cmd.capture)
        begin
            root_reg  <= hit_reg ? ROOT_WIDTH'(mid_reg) : ROOT_WIDTH'(lo_reg);
            exact_reg <= hit_reg;
        end
    end

    assign status.range_done = (wid_reg <= DATA_WIDTH'(1));
    assign status.square_hit = sq_equal;
    assign root              = root_reg;
    assign exact_hit         = exact_reg;

    `ASSERT_CLK(a_width_shrinks, (cmd.update && !sq_equal) |=> (wid_reg < $past(wid_reg)),
        "bisection width did not shrink")
    `ASSERT_CLK(a_exact_root, (cmd.capture && hit_reg) |=> (root_reg == ROOT_WIDTH'($past(mid_reg))),
        "exact result is not the midpoint")

endmodule

`default_nettype wire

FILE: design/bsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire bsr_pkg::bsr_status_t  status,
    output bsr_pkg::bsr_cmd_t          cmd
);
    import bsr_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SQUARE  = 2'd1;
    localparam logic [1:0] ST_COMPARE = 2'd2;
    localparam logic [1:0] ST_WRITE   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (status.range_done)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.square = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.update = 1'b1;
                state_next = status.square_hit ? ST_WRITE : ST_SQUARE;
            end
            ST_WRITE:
            begin
                // hold the result until the output register can take it
                if (slot_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_CLK(a_capture_free, cmd.capture |-> slot_free,
        "result captured over an untaken transaction")
    `ASSERT_CLK(a_capture_valid, cmd.capture |=> out_valid_reg,
        "captured result not presented")

endmodule

`default_nettype wire

FILE: design/bisection_square_root_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Port      Dir   Fields                       Transaction
// operand   sink  radicand[31:0] (Q16.16)      valid && ready
// result    src   root[24:0] (Q9.16), exact    valid && ready
//
// A load, then bisection rounds (square the midpoint, then compare and narrow),
// a check that sees the bounds touch, then a move into the output reg, held while
// the output reg still holds an untaken result. At most 32 rounds; an exact hit ends early.
// The 32x32 squaring multiplier is used once per round.
// rst_n clears the controller and the output valid; the datapath has no reset.
// A new operand is taken while the previous result still waits in the output register.

module bisection_square_root_unit (
    input wire logic  clk,
    input wire logic  rst_n,
    bsr_in_if.sink    operand,
    bsr_out_if.source result
);
    import bsr_pkg::*;

    bsr_cmd_t    cmd;
    bsr_status_t status;

    bsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .radicand  (operand.radicand),
        .cmd       (cmd),
        .status    (status),
        .root      (result.root),
        .exact_hit (result.exact_hit)
    );

    bsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsr_pkg::*;

    class root_checker;
        typedef struct {
            root_t root;
            logic  exact_hit;
        } root_expect_t;

        root_expect_t expected_roots[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // Bisect over [0, x], or [0, 1.0] below one, until the bounds touch or the square hits the target.
        static function void bisect_root(input data_t x, output root_t root,
                                         output logic exact);
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            logic [63:0] target;
            logic [63:0] sq;
            target = {32'b0, x} << FRACTION_BITS;
            lo     = '0;
            hi     = {32'b0, x};
            mid    = '0;
            exact  = 1'b0;
            if (x < FIX_ONE)
                hi = {32'b0, FIX_ONE};
            while (!exact && (hi - lo > 64'd1))
            begin
                mid = lo + ((hi - lo) >> 1);
                sq  = mid * mid;
                if (sq == target)
                    exact = 1'b1;
                else if (sq < target)
                    lo = mid;
                else
                    hi = mid;
            end
            root = exact ? mid[ROOT_WIDTH-1:0] : lo[ROOT_WIDTH-1:0];
        endfunction

        function void note_radicand(input data_t x);
            root_expect_t e;
            bisect_root(x, e.root, e.exact_hit);
            expected_roots.push_back(e);
        endfunction

        function void check_root(input root_t root, input logic exact_hit);
            root_expect_t e;
            if (expected_roots.size() == 0)
            begin
                $error("unexpected result transaction: root %h exact_hit %b",
                       root, exact_hit);
                errors++;
                return;
            end
            e = expected_roots.pop_front();
            if (root !== e.root)
            begin
                $error("root: expected %h, got %h", e.root, root);
                errors++;
            end
            if (exact_hit !== e.exact_hit)
            begin
                $error("exact_hit: expected %b, got %b", e.exact_hit, exact_hit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bsr_in_if  operand_if ();
    bsr_out_if result_if ();

    bisection_square_root_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_if),
        .result  (result_if)
    );

    root_checker root_check = new();

    int send_idle_pct = 29;
    int recv_idle_pct = 73;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && operand_if.valid && operand_if.ready)
            root_check.note_radicand(operand_if.radicand);
        if (rst_n && result_if.valid && result_if.ready)
            root_check.check_root(result_if.root, result_if.exact_hit);
    end

    task automatic send_radicand(input data_t x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            operand_if.valid <= 1'b0;
            @(posedge clk);
        end
        operand_if.valid    <= 1'b1;
        operand_if.radicand <= x;
        do
            @(posedge clk);
        while (!operand_if.ready);
    endtask

    // Mix of exact squares, their neighbors, sub-one values and wide values.
    function automatic data_t random_radicand();
        data_t       x;
        logic [31:0] a;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 40)
            x = $urandom;
        else if (pick < 65)
        begin
            a = $urandom_range(65535);
            x = a * a;
            case ($urandom_range(3))
                0: x = x + 1;
                1: x = x - 1;
                default: ;
            endcase
        end
        else if (pick < 85)
            x = $urandom_range(65535);
        else
            x = $urandom >> $urandom_range(31);
        return x;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_radicand(random_radicand());
    endtask

    initial
    begin
        data_t directed[$];
        rst_n               <= 1'b0;
        operand_if.valid    <= 1'b0;
        operand_if.radicand <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // zero, sub-one values, exact one, extremes and exact squares
        directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_4000, 32'h0000_FFFF,
                     32'h0001_0000, 32'h0001_0001, 32'h0002_4000, 32'h0004_0000,
                     32'h0000_0100, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFE_0001,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h0000_0002, 32'h0090_0000, 32'h0000_0004};
        foreach (directed[i])
            send_radicand(directed[i]);

        run_random(630);
        send_idle_pct = 73;
        recv_idle_pct = 29;
        run_random(630);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(640);
        operand_if.valid <= 1'b0;

        @(posedge clk);
        while (root_check.pending() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (root_check.errors == 0 && root_check.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bsr_pkg.sv
design/bsr_in_if.sv
design/bsr_out_if.sv
design/bsr_datapath.sv
design/bsr_ctrl.sv
design/bisection_square_root_unit.sv
tb/sv/testbench.sv
